/* hdl/itf_pkg.sv */
`default_nettype none
package itf_pkg;

    // Format kinds on the input tuser
    localparam logic [2:0] KIND_SDEC   = 3'd0;
    localparam logic [2:0] KIND_UDEC   = 3'd1;
    localparam logic [2:0] KIND_HEX_LO = 3'd2;
    localparam logic [2:0] KIND_HEX_UP = 3'd3;
    localparam logic [2:0] KIND_OCT    = 3'd4;

    // Digit buffer: 22 nibble slots cover 64-bit octal, 20-digit decimal, 16 hex
    localparam int DIG_SLOTS  = 22;
    localparam int DIG_BITS   = 4 * DIG_SLOTS;
    localparam int VAL_BITS   = 64;
    localparam int CONV_STEPS = VAL_BITS;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_UP_A  = 8'h41;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_PRE,
        ST_SKIP,
        ST_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic conv_step;
        logic pre_emit;
        logic zero_emit;
        logic skip_shift;
        logic dig_emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_dec;
        logic zero;
        logic pre_done;
        logic top_zero;
        logic dig_last;
        logic conv_last;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

/* hdl/itf_ctrl.sv */
`default_nettype none
module itf_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_tvalid,
    output logic                o_s_tready,
    input  itf_pkg::t_sts       i_sts,
    output itf_pkg::t_cmd       o_cmd
);
    import itf_pkg::*;

    t_state r_state;
    t_state n_state;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (!i_sts.is_dec || i_sts.conv_last) begin
                    n_state = ST_PRE;
                end
            end
            ST_PRE: begin
                if (i_sts.zero) begin
                    if (i_sts.out_free) begin
                        n_state = ST_IDLE;
                    end
                end else if (i_sts.pre_done) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (!i_sts.top_zero) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free && i_sts.dig_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs; refuse requests while reset is held
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = i_rst_n;
                o_cmd.load = i_s_tvalid && i_rst_n;
            end
            ST_CONV: begin
                o_cmd.conv_step = i_sts.is_dec;
            end
            ST_PRE: begin
                o_cmd.zero_emit = i_sts.zero && i_sts.out_free;
                o_cmd.pre_emit  = !i_sts.zero && !i_sts.pre_done && i_sts.out_free;
            end
            ST_SKIP: begin
                o_cmd.skip_shift = i_sts.top_zero;
            end
            ST_EMIT: begin
                o_cmd.dig_emit = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

/* hdl/itf_dpath.sv */
`default_nettype none
module itf_dpath (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire  [2:0]          i_kind,
    input  wire                 i_wide,
    input  wire  [63:0]         i_value,
    input  itf_pkg::t_cmd       i_cmd,
    output itf_pkg::t_sts       o_sts,
    output logic                o_m_tvalid,
    input  wire                 i_m_tready,
    output logic [7:0]          o_char,
    output logic                o_last
);
    import itf_pkg::*;

    logic [2:0]          r_kind;
    logic                r_neg;
    logic                r_zero;
    logic [1:0]          r_pre;
    logic [5:0]          r_conv_cnt;
    logic [4:0]          r_dig_cnt;
    logic [DIG_BITS-1:0] r_dig;
    logic [VAL_BITS-1:0] r_work;
    logic                r_ovalid;
    logic [7:0]          r_ochar;
    logic                r_olast;

    logic [VAL_BITS-1:0] val;
    logic                sign;
    logic                neg;
    logic [VAL_BITS-1:0] mag;
    logic [VAL_BITS+1:0] val_oct;
    logic [DIG_BITS-1:0] dig_oct;
    logic [DIG_BITS-1:0] dig_adj;
    logic                is_hex;
    logic                is_oct;
    logic                upper;
    logic [1:0]          plen;
    logic [3:0]          top;
    logic [7:0]          pre_char;
    logic [7:0]          dig_char;
    logic                out_free;

    // Mask the operand and take the magnitude of negative signed values
    always_comb begin
        val  = i_wide ? i_value : {32'd0, i_value[31:0]};
        sign = i_wide ? i_value[63] : i_value[31];
        neg  = (i_kind == KIND_SDEC) && sign;
        mag  = val;
        if (neg) begin
            mag = i_wide ? (64'd0 - i_value) : {32'd0, 32'd0 - i_value[31:0]};
        end
    end

    // Spread octal digits into nibble slots
    always_comb begin
        val_oct = {2'b00, val};
        for (int i = 0; i < DIG_SLOTS; i++) begin
            dig_oct[4*i +: 4] = {1'b0, val_oct[3*i +: 3]};
        end
    end

    // Add three to every BCD digit of five or more
    always_comb begin
        for (int i = 0; i < DIG_SLOTS; i++) begin
            dig_adj[4*i +: 4] = (r_dig[4*i +: 4] >= 4'd5) ? r_dig[4*i +: 4] + 4'd3
                                                          : r_dig[4*i +: 4];
        end
    end

    // Decode format and pick characters
    always_comb begin
        is_hex = (r_kind == KIND_HEX_LO) || (r_kind == KIND_HEX_UP);
        is_oct = (r_kind == KIND_OCT);
        upper  = (r_kind == KIND_HEX_UP);
        if (is_hex) begin
            plen = 2'd2;
        end else if (is_oct || r_neg) begin
            plen = 2'd1;
        end else begin
            plen = 2'd0;
        end
        if (is_hex) begin
            pre_char = (r_pre == 2'd0) ? CH_ZERO : (upper ? CH_UP_X : CH_LO_X);
        end else if (is_oct) begin
            pre_char = CH_ZERO;
        end else begin
            pre_char = CH_MINUS;
        end
        top = r_dig[DIG_BITS-1 -: 4];
        if (top < 4'd10) begin
            dig_char = CH_ZERO + {4'd0, top};
        end else begin
            dig_char = (upper ? CH_UP_A : CH_LO_A) + {4'd0, top} - 8'd10;
        end
        out_free = !r_ovalid || i_m_tready;
    end

    // Load, convert and shift the digit buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind     <= i_kind;
            r_neg      <= neg;
            r_zero     <= (val == '0);
            r_pre      <= 2'd0;
            r_conv_cnt <= 6'd0;
            r_dig_cnt  <= 5'(DIG_SLOTS);
            r_work     <= mag;
            if ((i_kind == KIND_HEX_LO) || (i_kind == KIND_HEX_UP)) begin
                r_dig <= {{(DIG_BITS-VAL_BITS){1'b0}}, val};
            end else if (i_kind == KIND_OCT) begin
                r_dig <= dig_oct;
            end else begin
                r_dig <= '0;
            end
        end else begin
            if (i_cmd.conv_step) begin
                r_dig      <= {dig_adj[DIG_BITS-2:0], r_work[VAL_BITS-1]};
                r_work     <= {r_work[VAL_BITS-2:0], 1'b0};
                r_conv_cnt <= r_conv_cnt + 6'd1;
            end
            if (i_cmd.pre_emit) begin
                r_pre <= r_pre + 2'd1;
            end
            if (i_cmd.skip_shift || i_cmd.dig_emit) begin
                r_dig     <= {r_dig[DIG_BITS-5:0], 4'd0};
                r_dig_cnt <= r_dig_cnt - 5'd1;
            end
        end
    end

    // Hold one character until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.pre_emit || i_cmd.zero_emit || i_cmd.dig_emit) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.zero_emit) begin
            r_ochar <= CH_ZERO;
            r_olast <= 1'b1;
        end else if (i_cmd.pre_emit) begin
            r_ochar <= pre_char;
            r_olast <= 1'b0;
        end else if (i_cmd.dig_emit) begin
            r_ochar <= dig_char;
            r_olast <= (r_dig_cnt == 5'd1);
        end
    end

    assign o_sts.is_dec    = !is_hex && !is_oct;
    assign o_sts.zero      = r_zero;
    assign o_sts.pre_done  = (r_pre == plen);
    assign o_sts.top_zero  = (top == 4'd0);
    assign o_sts.dig_last  = (r_dig_cnt == 5'd1);
    assign o_sts.conv_last = (r_conv_cnt == 6'(CONV_STEPS - 1));
    assign o_sts.out_free  = out_free;

    assign o_m_tvalid = r_ovalid;
    assign o_char     = r_ochar;
    assign o_last     = r_olast;

endmodule
`default_nettype wire

/* hdl/integer_to_text_formatter.sv */
`default_nettype none
// Hex and octal requests skip the conversion; decimal requests first run a
// shift-and-add-3 BCD conversion. Then the sign or prefix is sent and leading zeros skipped.
// Throughput: one character per cycle while the sink is ready, once leading zeros are skipped;
// one request in flight at a time, the next is taken while the last character waits.
// Reset (synchronous, active low) returns the controller to idle and empties the output.
module integer_to_text_formatter (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [63:0] i_s_tdata,   // [63:0] value
    input  wire  [3:0]  i_s_tuser,   // [2:0] kind, [3] wide
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] char_code
    output logic        o_m_tlast
);
    import itf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    itf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    itf_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_kind     (i_s_tuser[2:0]),
        .i_wide     (i_s_tuser[3]),
        .i_value    (i_s_tdata),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_char     (o_m_tdata),
        .o_last     (o_m_tlast)
    );

endmodule
`default_nettype wire

/* tb/text_stream_checker.sv */
`timescale 1ns / 100ps
// Watches both stream ports of the formatter, predicts the text of every
// accepted request and compares each character as it leaves the block.
module text_stream_checker
    import itf_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [63:0] i_s_tdata,   // [63:0] value
    input  wire  [3:0]  i_s_tuser,   // [2:0] kind, [3] wide
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [7:0]  i_m_tdata,   // [7:0] char_code
    input  wire         i_m_tlast,
    output int          o_fail_count = 0,
    output int          o_pending = 0
);

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } text_char_t;

    // Characters still owed by the block, oldest first
    text_char_t text_due[$];
    int         fails = 0;

    // Render one number as text and queue its characters, leading one first
    function automatic void predict_text(logic [2:0] kind, logic wide, logic [63:0] value);
        logic [63:0] mag;
        logic [7:0]  rev[$];
        logic [3:0]  nib;
        text_char_t  ch;
        int          k;
        mag = wide ? value : {32'd0, value[31:0]};
        if (mag == 64'd0) begin
            rev.push_back(CH_ZERO);
        end else begin
            case (kind)
                KIND_HEX_LO, KIND_HEX_UP: begin
                    while (mag != 64'd0) begin
                        nib = mag[3:0];
                        if (nib < 4'd10)
                            rev.push_back(CH_ZERO + 8'(nib));
                        else if (kind == KIND_HEX_UP)
                            rev.push_back(CH_UP_A + 8'(nib - 4'd10));
                        else
                            rev.push_back(CH_LO_A + 8'(nib - 4'd10));
                        mag = mag >> 4;
                    end
                    rev.push_back(kind == KIND_HEX_UP ? CH_UP_X : CH_LO_X);
                    rev.push_back(CH_ZERO);
                end
                KIND_OCT: begin
                    while (mag != 64'd0) begin
                        rev.push_back(CH_ZERO + 8'(mag[2:0]));
                        mag = mag >> 3;
                    end
                    rev.push_back(CH_ZERO);
                end
                default: begin
                    // Signed decimal negates within the operand width; the most
                    // negative value wraps to its exact unsigned magnitude
                    if (kind == KIND_SDEC && (wide ? mag[63] : mag[31])) begin
                        mag = -mag;
                        if (!wide)
                            mag[63:32] = 32'd0;
                        while (mag != 64'd0) begin
                            rev.push_back(CH_ZERO + 8'(mag % 64'd10));
                            mag = mag / 64'd10;
                        end
                        rev.push_back(CH_MINUS);
                    end else begin
                        while (mag != 64'd0) begin
                            rev.push_back(CH_ZERO + 8'(mag % 64'd10));
                            mag = mag / 64'd10;
                        end
                    end
                end
            endcase
        end
        for (k = rev.size() - 1; k >= 0; k--) begin
            ch.code = rev[k];
            ch.last = (k == 0);
            text_due.push_back(ch);
        end
    endfunction

    // Queue the text of each request, then check each character taken
    always @(posedge i_clk) begin
        text_char_t exp_ch;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                predict_text(i_s_tuser[2:0], i_s_tuser[3], i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                if (text_due.size() == 0) begin
                    $display("%0t: unexpected character: expected none, actual %h last %b",
                             $time, i_m_tdata, i_m_tlast);
                    fails++;
                end else begin
                    exp_ch = text_due.pop_front();
                    if (exp_ch.code !== i_m_tdata) begin
                        $display("%0t: char_code mismatch: expected %h, actual %h",
                                 $time, exp_ch.code, i_m_tdata);
                        fails++;
                    end
                    if (exp_ch.last !== i_m_tlast) begin
                        $display("%0t: last mismatch: expected %b, actual %b",
                                 $time, exp_ch.last, i_m_tlast);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= text_due.size();
    end

endmodule

/* tb/integer_to_text_formatter_test.sv */
`timescale 1ns / 100ps
module integer_to_text_formatter_test;
    import itf_pkg::*;

    // Kinds outside the defined set; the block formats them as unsigned decimal
    localparam logic [2:0] KIND_RSVD_5 = 3'd5;
    localparam logic [2:0] KIND_RSVD_6 = 3'd6;
    localparam logic [2:0] KIND_RSVD_7 = 3'd7;

    localparam int RANDOM_NUMBERS = 96;
    localparam int CALM_FROM      = 76;
    localparam int HOLD_AT        = 20;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;   // [63:0] value
    logic [3:0]  i_s_tuser;   // [2:0] kind, [3] wide
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;   // [7:0] char_code
    logic        o_m_tlast;

    int   fail_count;
    int   pending;
    logic calm = 1'b0;
    logic rx_hold_req = 1'b0;

    always #5 i_clk = ~i_clk;

    integer_to_text_formatter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    text_stream_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offer one request and hold it until taken, then maybe go quiet
    task automatic send_number(input logic [2:0] kind, input logic wide,
                               input logic [63:0] value);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tuser  <= {wide, kind};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    // Operands biased toward sign edges, powers of two and short texts
    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        int          n;
        case ($urandom_range(0, 5))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 99));
            2: begin
                n = $urandom_range(0, 63);
                v = (64'd1 << n) - 64'($urandom_range(0, 1));
            end
            3: v = {$urandom, 32'h7FFF_FFFF + 32'($urandom_range(0, 2))};
            4: v = ~64'($urandom_range(0, 99));
            default: v = 64'd0;
        endcase
        return v;
    endfunction

    // Receiver: random ready bursts, one long hold on request, steady at the end
    initial begin
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    // Sender and verdict
    initial begin
        logic [2:0] kind;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= 64'd0;
        i_s_tuser  <= 4'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero for every kind, with and without junk in the upper word
        send_number(KIND_SDEC,   1'b0, 64'd0);
        send_number(KIND_HEX_LO, 1'b0, 64'hFFFF_FFFF_0000_0000);
        send_number(KIND_OCT,    1'b1, 64'd0);
        send_number(KIND_UDEC,   1'b1, 64'd0);
        send_number(KIND_HEX_UP, 1'b1, 64'd0);
        send_number(KIND_RSVD_7, 1'b0, 64'd0);
        // Most negative values and the signed limits
        send_number(KIND_SDEC,   1'b0, 64'hDEAD_BEEF_8000_0000);
        send_number(KIND_SDEC,   1'b1, 64'h8000_0000_0000_0000);
        send_number(KIND_SDEC,   1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_number(KIND_SDEC,   1'b0, 64'h0000_0000_7FFF_FFFF);
        send_number(KIND_SDEC,   1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
        send_number(KIND_SDEC,   1'b1, 64'd1);
        // Longest texts of each radix, plus short hex and octal texts
        send_number(KIND_UDEC,   1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_number(KIND_UDEC,   1'b0, 64'h1234_5678_FFFF_FFFF);
        send_number(KIND_HEX_LO, 1'b1, 64'hFEDC_BA98_7654_3210);
        send_number(KIND_HEX_UP, 1'b1, 64'hFEDC_BA98_7654_3210);
        send_number(KIND_HEX_UP, 1'b0, 64'h5555_AAAA_ABCD_EF01);
        send_number(KIND_HEX_LO, 1'b0, 64'h0000_0000_0000_000A);
        send_number(KIND_OCT,    1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_number(KIND_OCT,    1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_number(KIND_OCT,    1'b1, 64'd1);
        // Undefined kinds behave as unsigned decimal
        send_number(KIND_RSVD_5, 1'b1, 64'd12345);
        send_number(KIND_RSVD_6, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_number(KIND_RSVD_7, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);

        for (int n = 0; n < RANDOM_NUMBERS; n++) begin
            if (n == HOLD_AT)
                rx_hold_req = 1'b1;
            if (n == CALM_FROM)
                calm = 1'b1;
            if ($urandom_range(0, 9) == 0)
                kind = 3'($urandom_range(5, 7));
            else
                kind = 3'($urandom_range(0, 4));
            send_number(kind, 1'($urandom_range(0, 1)), pick_value());
        end
        i_s_tvalid <= 1'b0;

        // Drain the text still owed, then watch for stray characters
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
